FILE: design/esd_pkg.sv
// Package for the escape sequence decoder: character constants, decode modes,
// the queue entry type and digit helper functions.
// Depends on nothing; the top, front, queue and back design files import it.
package esd_pkg;

    localparam int QUEUE_AW_DEF = 2;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_HEX2   = 3'd3,
        MODE_OCT1   = 3'd4,
        MODE_OCT2   = 3'd5
    } mode_t;

    // All results caused by one accepted item.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            bvalid;
        logic            last;
    } bundle_t;

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46))
            || ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        if (b <= 8'h39) begin
            v = b[3:0];
        end else begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

FILE: design/escape_sequence_decoder_top.sv
// Top level of the escape sequence decoder.
// Instantiates esd_front, esd_queue and esd_back; depends on esd_pkg.
//
// The slave channel takes one raw byte of a C-style escaped string per item,
// with s_tlast on the final byte. The master channel gives decoded bytes, each
// with a flag that the byte is real, a flag on the last result caused by an
// input item, and m_tlast on the final result of the string. A string whose
// final byte yields nothing gives one result with the byte flag clear.
// An accepted item is written into the bundle queue, and its results are
// then loaded from it into the output register. The front accepts one item
// per cycle as long as the four-entry bundle queue has room; the back gives
// one result per cycle while the queue holds one and the receiver is ready,
// and items that yield nothing, but for a string's final byte, skip the queue.
// When the receiver stalls, the output register holds its result, the queue
// fills, and s_tready falls once it is full.
// Reset empties the queue, clears the output valid flag and returns the
// decoder to normal mode with cleared hold registers.
module escape_sequence_decoder_top import esd_pkg::*; #(
    parameter int QUEUE_AW = QUEUE_AW_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // byte_valid, run_last
    output logic       m_tlast
);

    bundle_t push_data, head;
    logic    push, pop, full, empty;

    esd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    esd_queue #(
        .QUEUE_AW (QUEUE_AW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    esd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (empty),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: design/esd_front.sv
// Front part of the escape sequence decoder: accepts raw bytes, tracks the
// escape mode and builds the list of decoded bytes for each item.
// Depends on esd_pkg.
module esd_front import esd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output bundle_t    q_data
);

    mode_t           mode_reg, mode_next, mode_step;
    logic [7:0]      hf_reg, hf_next, hf_step;
    logic [7:0]      hs_reg, hs_next, hs_step;
    logic            accept;
    logic [2:0][7:0] e;
    logic [1:0]      n;
    logic [7:0]      b;

    assign b        = s_tdata;
    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_comb begin
        mode_step = mode_reg;
        hf_step   = hf_reg;
        hs_step   = hs_reg;
        case (mode_reg)
            MODE_ESC: begin
                if (b == CH_X) begin
                    mode_step = MODE_HEX1;
                end else if (is_octal(b)) begin
                    hf_step   = b;
                    mode_step = MODE_OCT1;
                end else begin
                    mode_step = MODE_NORMAL;
                end
            end
            MODE_HEX1: begin
                if (is_hex(b)) begin
                    hf_step   = b;
                    mode_step = MODE_HEX2;
                end else begin
                    mode_step = MODE_NORMAL;
                end
            end
            MODE_HEX2: mode_step = MODE_NORMAL;
            MODE_OCT1: begin
                if (is_octal(b)) begin
                    hs_step   = b;
                    mode_step = MODE_OCT2;
                end else begin
                    mode_step = (b == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
                end
            end
            MODE_OCT2: begin
                if (is_octal(b)) begin
                    mode_step = MODE_NORMAL;
                end else begin
                    mode_step = (b == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
                end
            end
            default: mode_step = (b == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
        endcase
        mode_next = mode_reg;
        hf_next   = hf_reg;
        hs_next   = hs_reg;
        if (accept) begin
            mode_next = s_tlast ? MODE_NORMAL : mode_step;
            hf_next   = s_tlast ? 8'h00 : hf_step;
            hs_next   = s_tlast ? 8'h00 : hs_step;
        end
    end

    always_comb begin
        e = '0;
        n = 2'd0;
        case (mode_reg)
            MODE_ESC: begin
                if (b == CH_R) begin
                    e[n] = CH_CR;
                    n = n + 2'd1;
                end else if (b == CH_N) begin
                    e[n] = CH_LF;
                    n = n + 2'd1;
                end else if (b == CH_T) begin
                    e[n] = CH_TAB;
                    n = n + 2'd1;
                end else if ((b != CH_X) && !is_octal(b)) begin
                    e[n] = b;
                    n = n + 2'd1;
                end
            end
            MODE_HEX1: begin
                if (!is_hex(b)) begin
                    e[0] = CH_X;
                    e[1] = b;
                    n = 2'd2;
                end
            end
            MODE_HEX2: begin
                if (is_hex(hf_reg) && is_hex(b)) begin
                    e[0] = {hex_val(hf_reg), hex_val(b)};
                    n = 2'd1;
                end else begin
                    e[0] = CH_X;
                    e[1] = hf_reg;
                    e[2] = b;
                    n = 2'd3;
                end
            end
            MODE_OCT1: begin
                if (!is_octal(b)) begin
                    e[n] = hf_reg;
                    n = n + 2'd1;
                    if (b != CH_BSLASH) begin
                        e[n] = b;
                        n = n + 2'd1;
                    end
                end
            end
            MODE_OCT2: begin
                if (is_octal(b)) begin
                    e[n] = {hf_reg[1:0], hs_reg[2:0], b[2:0]};
                    n = n + 2'd1;
                end else begin
                    e[n] = hf_reg;
                    n = n + 2'd1;
                    e[n] = hs_reg;
                    n = n + 2'd1;
                    if (b != CH_BSLASH) begin
                        e[n] = b;
                        n = n + 2'd1;
                    end
                end
            end
            default: begin
                if (b != CH_BSLASH) begin
                    e[n] = b;
                    n = n + 2'd1;
                end
            end
        endcase
        if (s_tlast) begin
            case (mode_step)
                MODE_HEX1: begin
                    e[n] = CH_X;
                    n = n + 2'd1;
                end
                MODE_HEX2: begin
                    e[n] = CH_X;
                    n = n + 2'd1;
                    e[n] = hf_step;
                    n = n + 2'd1;
                end
                MODE_OCT1: begin
                    e[n] = hf_step;
                    n = n + 2'd1;
                end
                MODE_OCT2: begin
                    e[n] = hf_step;
                    n = n + 2'd1;
                    e[n] = hs_step;
                    n = n + 2'd1;
                end
                default: ;
            endcase
        end
        q_data.bytes  = e;
        q_data.cnt    = (n == 2'd0) ? 2'd1 : n;
        q_data.bvalid = (n != 2'd0);
        q_data.last   = s_tlast;
        q_push        = accept && ((n != 2'd0) || s_tlast);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            hf_reg   <= 8'h00;
            hs_reg   <= 8'h00;
        end else begin
            mode_reg <= mode_next;
            hf_reg   <= hf_next;
            hs_reg   <= hs_next;
        end
    end

endmodule

FILE: design/esd_queue.sv
// Short queue of decoded bundles between the front and back parts.
// Depends on esd_pkg for the entry type.
module esd_queue import esd_pkg::*; #(
    parameter int QUEUE_AW = QUEUE_AW_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    empty,
    output bundle_t head
);

    localparam int DEPTH = 1 << QUEUE_AW;

    bundle_t             entries [DEPTH];
    logic [QUEUE_AW:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW:0]   rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW])
                && (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);
    assign head  = entries[rd_ptr_reg[QUEUE_AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + {{QUEUE_AW{1'b0}}, (push && !full)};
    assign rd_ptr_next = rd_ptr_reg + {{QUEUE_AW{1'b0}}, (pop && !empty)};

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entries[wr_ptr_reg[QUEUE_AW-1:0]] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

FILE: design/esd_back.sv
// Back part of the escape sequence decoder: walks each queued bundle one
// result at a time into the output register.
// Depends on esd_pkg.
module esd_back import esd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  bundle_t    q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [1:0] m_tuser,
    output logic       m_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       bvalid_reg, run_last_reg, end_reg;
    logic       load, fin;

    assign load  = !q_empty && (!valid_reg || m_tready);
    assign fin   = (idx_reg == (q_head.cnt - 2'd1));
    assign q_pop = load && fin;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = fin ? 2'd0 : idx_reg + 2'd1;
        end
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg     <= q_head.bytes[idx_reg];
            bvalid_reg   <= q_head.bvalid;
            run_last_reg <= fin;
            end_reg      <= fin && q_head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {run_last_reg, bvalid_reg};
    assign m_tlast  = end_reg;

endmodule

FILE: design/esd_checker.sv
// Port-level checker for the escape sequence decoder and its bind statement.
// Depends on escape_sequence_decoder_top.
module esd_port_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("Stalled output item changed.");

    a_end_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("String end without run end.");

    a_empty_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00 && m_tuser[1] && m_tlast)
        else $error("Empty item outside string end.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

endmodule

bind escape_sequence_decoder_top esd_port_checker u_esd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: sim/esd_checker.sv
`timescale 1ns / 1ps
// Checker for the escape sequence decoder: watches both stream channels, predicts the
// decoded results of every accepted item and compares them field by field.
// Depends on esd_pkg for the character constants and the decode modes.
module esd_checker import esd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       has_byte;
        logic       item_end;
        logic       str_end;
    } dec_result_t;

    mode_t       dmode;
    logic [7:0]  hold_a;
    logic [7:0]  hold_b;
    dec_result_t decoded_q[$];
    dec_result_t want;
    int          n_results;

    initial begin
        fail_count = 0;
        pending = 0;
        n_results = 0;
        dmode = MODE_NORMAL;
        hold_a = 8'h00;
        hold_b = 8'h00;
    end

    function automatic logic oct_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "7");
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
        return 5'b10000;
    endfunction

    function automatic void take_plain(input logic [7:0] c, ref logic [7:0] outs[$]);
        if (c == CH_BSLASH) begin
            dmode = MODE_ESC;
        end else begin
            outs.push_back(c);
            dmode = MODE_NORMAL;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic fin);
        logic [7:0]  outs[$];
        logic [4:0]  hi;
        logic [4:0]  lo;
        dec_result_t r;
        int          n;
        case (dmode)
            MODE_ESC: begin
                dmode = MODE_NORMAL;
                if (c == CH_X) begin
                    dmode = MODE_HEX1;
                end else if (oct_digit(c)) begin
                    hold_a = c;
                    dmode = MODE_OCT1;
                end else if (c == CH_R) begin
                    outs.push_back(CH_CR);
                end else if (c == CH_N) begin
                    outs.push_back(CH_LF);
                end else if (c == CH_T) begin
                    outs.push_back(CH_TAB);
                end else begin
                    outs.push_back(c);
                end
            end
            MODE_HEX1: begin
                lo = hex_nibble(c);
                if (!lo[4]) begin
                    hold_a = c;
                    dmode = MODE_HEX2;
                end else begin
                    outs.push_back(CH_X);
                    outs.push_back(c);
                    dmode = MODE_NORMAL;
                end
            end
            MODE_HEX2: begin
                hi = hex_nibble(hold_a);
                lo = hex_nibble(c);
                if (!hi[4] && !lo[4]) begin
                    outs.push_back({hi[3:0], lo[3:0]});
                end else begin
                    outs.push_back(CH_X);
                    outs.push_back(hold_a);
                    outs.push_back(c);
                end
                dmode = MODE_NORMAL;
            end
            MODE_OCT1: begin
                if (oct_digit(c)) begin
                    hold_b = c;
                    dmode = MODE_OCT2;
                end else begin
                    outs.push_back(hold_a);
                    take_plain(c, outs);
                end
            end
            MODE_OCT2: begin
                if (oct_digit(c)) begin
                    outs.push_back({hold_a[1:0], hold_b[2:0], c[2:0]});
                    dmode = MODE_NORMAL;
                end else begin
                    outs.push_back(hold_a);
                    outs.push_back(hold_b);
                    take_plain(c, outs);
                end
            end
            default: take_plain(c, outs);
        endcase

        if (fin) begin
            case (dmode)
                MODE_HEX1: outs.push_back(CH_X);
                MODE_HEX2: begin
                    outs.push_back(CH_X);
                    outs.push_back(hold_a);
                end
                MODE_OCT1: outs.push_back(hold_a);
                MODE_OCT2: begin
                    outs.push_back(hold_a);
                    outs.push_back(hold_b);
                end
                default: ;
            endcase
            dmode = MODE_NORMAL;
            hold_a = 8'h00;
            hold_b = 8'h00;
        end

        n = (outs.size() > 3) ? 3 : outs.size();
        for (int k = 0; k < n; k++) begin
            r.value = outs[k];
            r.has_byte = 1'b1;
            r.item_end = (k == n - 1);
            r.str_end = (k == n - 1) && fin;
            decoded_q.push_back(r);
        end
        if (n == 0 && fin) begin
            r = '{value: 8'h00, has_byte: 1'b0, item_end: 1'b1, str_end: 1'b1};
            decoded_q.push_back(r);
        end
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at result %0d: %s", n_results, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            dmode = MODE_NORMAL;
            hold_a = 8'h00;
            hold_b = 8'h00;
            decoded_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result, byte %02h", m_tdata));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.value) begin
                        flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                                m_tdata, want.value));
                    end
                    if (m_tuser[0] !== want.has_byte) begin
                        flag_mismatch($sformatf("byte_valid %b, expected %b",
                                                m_tuser[0], want.has_byte));
                    end
                    if (m_tuser[1] !== want.item_end) begin
                        flag_mismatch($sformatf("run_last %b, expected %b",
                                                m_tuser[1], want.item_end));
                    end
                    if (m_tlast !== want.str_end) begin
                        flag_mismatch($sformatf("string_end %b, expected %b",
                                                m_tlast, want.str_end));
                    end
                end
                n_results++;
            end
        end
        pending = decoded_q.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for escape_sequence_decoder_top: drives escaped strings with random
// gaps and receiver stalls, and gives the verdict from the count of esd_checker.
// Depends on esd_pkg, esd_checker and the decoder RTL.
module tb;
    import esd_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;
    logic       calm = 1'b0;
    logic       hold_req = 1'b0;
    logic       hold_done = 1'b0;
    int         fail_count;
    int         pending;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    escape_sequence_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    esd_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver stalls at random, never while calm, and holds off for a long
    // stretch once on request so that the decoder fills up.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                hold_done <= 1'b1;
                repeat (60) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 32);
                @(posedge aclk);
            end
        end
    end

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] rand_hex_digit();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'("0" + v);
        return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] rand_oct_digit();
        return 8'("0" + $urandom_range(7));
    endfunction

    function automatic byte_q_t make_phrase();
        byte_q_t q;
        int      tokens;
        tokens = $urandom_range(8, 1);
        for (int t = 0; t < tokens; t++) begin
            case ($urandom_range(9))
                0, 1, 2: q.push_back(8'($urandom_range(255)));
                3: begin
                    q.push_back(CH_BSLASH);
                    case ($urandom_range(3))
                        0: q.push_back(CH_R);
                        1: q.push_back(CH_N);
                        2: q.push_back(CH_T);
                        default: q.push_back(8'($urandom_range(255)));
                    endcase
                end
                4, 5: begin
                    q.push_back(CH_BSLASH);
                    q.push_back(CH_X);
                    q.push_back(rand_hex_digit());
                    q.push_back(rand_hex_digit());
                end
                6: begin
                    q.push_back(CH_BSLASH);
                    q.push_back(CH_X);
                    q.push_back($urandom_range(1) ? rand_hex_digit() : 8'($urandom_range(255)));
                    q.push_back(8'($urandom_range(255)));
                end
                7, 8: begin
                    q.push_back(CH_BSLASH);
                    repeat (3) q.push_back(rand_oct_digit());
                end
                default: begin
                    q.push_back(CH_BSLASH);
                    repeat ($urandom_range(2, 1)) q.push_back(rand_oct_digit());
                    q.push_back(8'($urandom_range(255)));
                end
            endcase
        end
        if ($urandom_range(9) == 0) q.push_back(CH_BSLASH);
        return q;
    endfunction

    task automatic push_item(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic send_bytes(input byte_q_t q);
        for (int i = 0; i < q.size(); i++) push_item(q[i], i == q.size() - 1);
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    initial begin
        byte_q_t phrase;
        int      sent;
        bit      held;
        bit      paused;
        sent = 0;
        held = 0;
        paused = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        phrase = {8'h00, 8'hFF};
        send_bytes(phrase);
        send_bytes(text_bytes("\\n\\r\\t\\q"));
        send_bytes(text_bytes("\\xaF\\xG"));
        send_bytes(text_bytes("\\x4g"));
        send_bytes(text_bytes("\\777\\12A"));
        send_bytes(text_bytes("\\1\\"));
        send_bytes(text_bytes("\\x4"));
        send_bytes(text_bytes("\\12"));
        drain_outputs();

        while (sent < 280) begin
            phrase = make_phrase();
            calm <= (sent >= 120 && sent < 180);
            if (!held && sent >= 60) begin
                hold_req <= 1'b1;
                held = 1;
            end
            if (!paused && sent >= 200) begin
                drain_outputs();
                paused = 1;
            end
            send_bytes(phrase);
            sent += phrase.size();
        end
        drain_outputs();
        repeat (12) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[escape_sequence_decoder_top] OK");
        end else begin
            $display("[escape_sequence_decoder_top] ERROR");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("[escape_sequence_decoder_top] ERROR");
        $finish;
    end

endmodule
